// ===== src/background_tile_fetch_addresser_core_assert.svh =====
// assertion helpers for the fetch addresser core
`ifndef BACKGROUND_TILE_FETCH_ADDRESSER_CORE_ASSERT_SVH
`define BACKGROUND_TILE_FETCH_ADDRESSER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BTFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fetch addresser check failed");

// consequent checked in the cycle after the antecedent
`define BTFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fetch addresser check failed");

`endif

// ===== src/btfa_pkg.sv =====
`default_nettype none

package btfa_pkg;

    // input and result field widths
    localparam int COLUMN_W = 9;
    localparam int ROW_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int SCROLL_W = 7;
    localparam int ADDR_W   = 15;
    localparam int COUNT_W  = 32;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // bit positions of the result flags in the output tdata
    localparam int OUT_ACTIVE_BIT = 15;
    localparam int OUT_ATTR_BIT   = 16;

    // fixed limits of the fetch scheme
    localparam logic [SCROLL_W-1:0] VSCROLL_LIMIT = 7'd119;
    localparam logic [5:0]          MAX_TILE_ROW  = 6'd14;
    localparam logic [ROW_W-1:0]    VISIBLE_ROWS  = 9'd240;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SCROLL_H = 1'b0,
        REG_SCROLL_V = 1'b1
    } cfg_reg_t;

    // one dot as it arrives on the input stream
    typedef struct packed {
        logic [COLUMN_W-1:0] beam_column;
        logic [ROW_W-1:0]    beam_row;
        logic                horizontal_blank;
        logic                vertical_blank;
        logic                processor_phase;
        logic                capture_valid;
        logic [BYTE_W-1:0]   capture_byte;
    } in_beat_t;

    // decoded fetch for one dot
    typedef struct packed {
        logic              active;
        logic              attr;
        logic [ADDR_W-1:0] address;
    } fetch_info_t;

endpackage

`default_nettype wire

// ===== src/btfa_addr_gen.sv =====
`default_nettype none

module btfa_addr_gen #(
    parameter int SCREEN_WIDTH_PIXELS  = 128,
    parameter int SCREEN_HEIGHT_PIXELS = 120,
    parameter int SCREEN_TILES_WIDE    = 16,
    parameter int SLOT_SIZE_BYTES      = 1024,
    parameter int ATTRIBUTE_OFFSET     = 256
) (
    input  wire btfa_pkg::in_beat_t             beat,
    input  wire logic [btfa_pkg::SCROLL_W-1:0]  scroll_h,
    input  wire logic [btfa_pkg::SCROLL_W-1:0]  scroll_v,
    output btfa_pkg::fetch_info_t               info
);
    import btfa_pkg::*;

    // reciprocal constants for the slot divide, exact for any 9-bit position
    localparam int X_SHIFT = 9 + $clog2(SCREEN_WIDTH_PIXELS);
    localparam int Y_SHIFT = 9 + $clog2(SCREEN_HEIGHT_PIXELS);
    localparam int X_RECIP = (2 ** X_SHIFT + SCREEN_WIDTH_PIXELS - 1) / SCREEN_WIDTH_PIXELS;
    localparam int Y_RECIP = (2 ** Y_SHIFT + SCREEN_HEIGHT_PIXELS - 1) / SCREEN_HEIGHT_PIXELS;

    logic       visible;
    logic       active;
    logic       attr;
    logic [8:0] sx;
    logic [8:0] sy;
    logic [19:0] px;
    logic [19:0] py;
    logic       bx;
    logic       by;
    logic [8:0] lx;
    logic [8:0] ly;
    logic [5:0] tx;
    logic [5:0] ty;
    logic [ADDR_W-1:0] tile_index;
    logic [ADDR_W-1:0] addr;

    // dot decode
    always_comb
    begin
        visible = !beat.horizontal_blank && !beat.vertical_blank &&
                  !beat.beam_column[COLUMN_W-1] && (beat.beam_row < VISIBLE_ROWS);
        active  = visible && !beat.processor_phase;
        attr    = active && beat.beam_column[0];
    end

    // scrolled logical position and screen slot
    always_comb
    begin
        sx = {2'b00, scroll_h} + {1'b0, beat.beam_column[COLUMN_W-1:1]};
        sy = {2'b00, scroll_v} + {1'b0, beat.beam_row[ROW_W-1:1]};
        // quotient bit zero of position / span through the reciprocal product
        px = 20'(sx) * 20'(X_RECIP);
        py = 20'(sy) * 20'(Y_RECIP);
        bx = px[X_SHIFT];
        by = py[Y_SHIFT];
        lx = bx ? (sx - 9'(SCREEN_WIDTH_PIXELS)) : sx;
        ly = by ? (sy - 9'(SCREEN_HEIGHT_PIXELS)) : sy;
    end

    // clamped tile cell and final address
    always_comb
    begin
        tx = lx[8:3];
        ty = ly[8:3];
        if (tx >= 6'(SCREEN_TILES_WIDE))
        begin
            tx = 6'(SCREEN_TILES_WIDE - 1);
        end
        if (ty > MAX_TILE_ROW)
        begin
            ty = MAX_TILE_ROW;
        end
        tile_index = ADDR_W'(ty) * ADDR_W'(SCREEN_TILES_WIDE) + ADDR_W'(tx);
        addr = ADDR_W'({by, bx}) * ADDR_W'(SLOT_SIZE_BYTES) + tile_index;
        if (attr)
        begin
            addr = addr + ADDR_W'(ATTRIBUTE_OFFSET);
        end
        info.active  = active;
        info.attr    = attr;
        info.address = active ? addr : '0;
    end

endmodule

`default_nettype wire

// ===== src/background_tile_fetch_addresser_core.sv =====
// Background tile fetch addresser: one dot of beam position per input beat.
// Input stream s_axis carries the beam column and row, the blanking and CPU
// phase flags and an optional byte captured from video memory. Output stream
// m_axis returns one beat per input beat: the video memory address, the
// fetch and attribute flags, both byte latches and the capture count.
// Scroll registers are written on the cfg port (index 0 horizontal, index 1
// vertical, the latter saturating at 119); the user must write them only while
// the stream is idle; the block itself does not enforce it. A dot passes an input
// register, the address logic and a result register. Throughput is one beat
// per cycle while m_axis_tready is high; while a finished result waits, the
// input side still takes one beat as long as the input register is empty.
// When m_axis_tready is low the result holds and s_axis_tready drops once
// the input register is also full; nothing is lost or repeated.
// Reset clears the scroll registers, both latches and the capture count
// and empties both pipeline registers.
`default_nettype none

module background_tile_fetch_addresser_core #(
    parameter int SCREEN_WIDTH_PIXELS  = 128,
    parameter int SCREEN_HEIGHT_PIXELS = 120,
    parameter int SCREEN_TILES_WIDE    = 16,
    parameter int SLOT_SIZE_BYTES      = 1024,
    parameter int ATTRIBUTE_OFFSET     = 256
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input dots
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // beam_column[8:0], beam_row[17:9], horizontal_blank[18], vertical_blank[19],
    // processor_phase[20], capture_valid[21], capture_byte[29:22], zero[31:30]
    input  wire logic [btfa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // results
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // video_address[14:0], fetch_active[15], attribute_cycle[16],
    // tile_latch[24:17], attribute_latch[32:25], fetch_total[64:33], zero[71:65]
    output logic [btfa_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // configuration writes
    input  wire logic                                 cfg_we,
    input  wire btfa_pkg::cfg_reg_t                   cfg_index,
    input  wire logic [btfa_pkg::SCROLL_W-1:0]        cfg_data
);
    import btfa_pkg::*;

    logic                      in_valid_reg;
    logic                      in_valid_next;
    in_beat_t                  in_beat_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [OUT_TDATA_W-1:0]    out_data_reg;
    logic [OUT_TDATA_W-1:0]    out_data_next;
    logic [SCROLL_W-1:0]       scroll_h_reg;
    logic [SCROLL_W-1:0]       scroll_v_reg;
    logic [BYTE_W-1:0]         tile_reg;
    logic [BYTE_W-1:0]         tile_next;
    logic [BYTE_W-1:0]         attr_latch_reg;
    logic [BYTE_W-1:0]         attr_latch_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      in_fire;
    logic                      out_ready;
    logic                      out_load;
    logic                      cap_hit;
    in_beat_t                  in_beat;
    fetch_info_t               info;

    // handshake
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign out_load      = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // unpack the input beat
    always_comb
    begin
        in_beat.beam_column      = s_axis_tdata[8:0];
        in_beat.beam_row         = s_axis_tdata[17:9];
        in_beat.horizontal_blank = s_axis_tdata[18];
        in_beat.vertical_blank   = s_axis_tdata[19];
        in_beat.processor_phase  = s_axis_tdata[20];
        in_beat.capture_valid    = s_axis_tdata[21];
        in_beat.capture_byte     = s_axis_tdata[29:22];
    end

    btfa_addr_gen #(
        .SCREEN_WIDTH_PIXELS  (SCREEN_WIDTH_PIXELS),
        .SCREEN_HEIGHT_PIXELS (SCREEN_HEIGHT_PIXELS),
        .SCREEN_TILES_WIDE    (SCREEN_TILES_WIDE),
        .SLOT_SIZE_BYTES      (SLOT_SIZE_BYTES),
        .ATTRIBUTE_OFFSET     (ATTRIBUTE_OFFSET)
    ) u_addr_gen (
        .beat     (in_beat_reg),
        .scroll_h (scroll_h_reg),
        .scroll_v (scroll_v_reg),
        .info     (info)
    );

    // latch and counter update for the dot moving to the result register
    always_comb
    begin
        cap_hit         = info.active && in_beat_reg.capture_valid;
        tile_next       = tile_reg;
        attr_latch_next = attr_latch_reg;
        count_next      = count_reg;
        if (out_load && cap_hit)
        begin
            if (info.attr)
            begin
                attr_latch_next = in_beat_reg.capture_byte;
            end
            else
            begin
                tile_next = in_beat_reg.capture_byte;
            end
            count_next = count_reg + 32'd1;
        end
        out_data_next = {7'd0, count_next, attr_latch_next, tile_next,
                         info.attr, info.active, info.address};
    end

    // pipeline valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state, latches and scroll registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tile_reg       <= '0;
            attr_latch_reg <= '0;
            count_reg      <= '0;
            scroll_h_reg   <= '0;
            scroll_v_reg   <= '0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            tile_reg       <= tile_next;
            attr_latch_reg <= attr_latch_next;
            count_reg      <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCROLL_H:
                    begin
                        scroll_h_reg <= cfg_data;
                    end
                    REG_SCROLL_V:
                    begin
                        scroll_v_reg <= (cfg_data > VSCROLL_LIMIT) ? VSCROLL_LIMIT : cfg_data;
                    end
                    default:
                    begin
                        scroll_h_reg <= scroll_h_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_beat_reg <= in_beat;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

`include "background_tile_fetch_addresser_core_assert.svh"

    // captured byte bumps the count by one
    `BTFA_ASSERT_NEXT(a_count_step, clk, rst_n, out_load && cap_hit, count_reg == $past(count_reg) + 32'd1)
    // no capture, no count change
    `BTFA_ASSERT_NEXT(a_count_hold, clk, rst_n, !(out_load && cap_hit), $stable(count_reg))
    // idle dots give a zero address
    `BTFA_ASSERT_SAME(a_idle_addr, clk, rst_n, out_valid_reg && !out_data_reg[OUT_ACTIVE_BIT], out_data_reg[ADDR_W-1:0] == '0)
    // attribute fetch only during an active fetch
    `BTFA_ASSERT_SAME(a_attr_active, clk, rst_n, out_valid_reg && out_data_reg[OUT_ATTR_BIT], out_data_reg[OUT_ACTIVE_BIT])
    // a held input dot is not dropped while the result side stalls
    `BTFA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !out_load, in_valid_reg)

endmodule

`default_nettype wire
